/* design/dtcf_pkg.sv */
// Shared types and constants for the direction to cube face texel block.
package dtcf_pkg;

	localparam int FACE_SIZE_DEF = 1024;
	localparam int COMP_W = 16;
	localparam int MAG_W = 16;
	localparam int D_W = 17;
	localparam int TEX_W = 10;

	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] dir_x;
		logic signed [COMP_W-1:0] dir_y;
		logic signed [COMP_W-1:0] dir_z;
	} dir_t;

	typedef struct packed {
		face_t            face;
		logic [TEX_W-1:0] tex_x;
		logic [TEX_W-1:0] tex_y;
		logic             zero_vector;
	} texel_t;

	typedef struct packed {
		face_t face;
		logic  zero_vector;
	} dtcf_tag_t;

endpackage

/* design/dtcf_div.sv */
// Pipelined restoring divider for both face coordinates, one quotient bit per stage.
module dtcf_div
	import dtcf_pkg::*;
#(
	parameter int FACE_SIZE = FACE_SIZE_DEF,
	localparam int QW = $clog2(FACE_SIZE + 1),
	localparam int NW = D_W + QW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  logic [NW-1:0]   num_u,
	input  logic [NW-1:0]   num_v,
	input  logic [D_W-1:0]  den,
	input  dtcf_tag_t       tag_in,
	output logic            valid_out,
	output logic [QW-1:0]   quo_u,
	output logic [QW-1:0]   quo_v,
	output dtcf_tag_t       tag_out
);

	logic            valid_s [QW];
	logic [D_W-1:0]  rem_u_s [QW];
	logic [D_W-1:0]  rem_v_s [QW];
	logic [QW-1:0]   low_u_s [QW];
	logic [QW-1:0]   low_v_s [QW];
	logic [QW-1:0]   quo_u_s [QW];
	logic [QW-1:0]   quo_v_s [QW];
	logic [D_W-1:0]  den_s   [QW];
	dtcf_tag_t       tag_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic            valid_i;
		logic [D_W-1:0]  rem_u_i;
		logic [D_W-1:0]  rem_v_i;
		logic [QW-1:0]   low_u_i;
		logic [QW-1:0]   low_v_i;
		logic [QW-1:0]   quo_u_i;
		logic [QW-1:0]   quo_v_i;
		logic [D_W-1:0]  den_i;
		dtcf_tag_t       tag_i;
		logic [D_W:0]    trial_u;
		logic [D_W:0]    trial_v;
		logic            ge_u;
		logic            ge_v;
		logic [D_W:0]    diff_u;
		logic [D_W:0]    diff_v;

		if (i == 0) begin : g_src
			// The upper bits of the numerator are already below the divisor, since the
			// quotient never exceeds the face size.
			assign valid_i = valid_in;
			assign rem_u_i = num_u[NW-1:QW];
			assign rem_v_i = num_v[NW-1:QW];
			assign low_u_i = num_u[QW-1:0];
			assign low_v_i = num_v[QW-1:0];
			assign quo_u_i = '0;
			assign quo_v_i = '0;
			assign den_i   = den;
			assign tag_i   = tag_in;
		end else begin : g_src
			assign valid_i = valid_s[i-1];
			assign rem_u_i = rem_u_s[i-1];
			assign rem_v_i = rem_v_s[i-1];
			assign low_u_i = low_u_s[i-1];
			assign low_v_i = low_v_s[i-1];
			assign quo_u_i = quo_u_s[i-1];
			assign quo_v_i = quo_v_s[i-1];
			assign den_i   = den_s[i-1];
			assign tag_i   = tag_s[i-1];
		end

		always_comb begin
			trial_u = {rem_u_i, low_u_i[QW-1]};
			trial_v = {rem_v_i, low_v_i[QW-1]};
			ge_u    = trial_u >= {1'b0, den_i};
			ge_v    = trial_v >= {1'b0, den_i};
			diff_u  = trial_u - {1'b0, den_i};
			diff_v  = trial_v - {1'b0, den_i};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_u_s[i] <= ge_u ? diff_u[D_W-1:0] : trial_u[D_W-1:0];
			rem_v_s[i] <= ge_v ? diff_v[D_W-1:0] : trial_v[D_W-1:0];
			low_u_s[i] <= low_u_i << 1;
			low_v_s[i] <= low_v_i << 1;
			quo_u_s[i] <= {quo_u_i[QW-2:0], ge_u};
			quo_v_s[i] <= {quo_v_i[QW-2:0], ge_v};
			den_s[i]   <= den_i;
			tag_s[i]   <= tag_i;
		end
	end

	assign valid_out = valid_s[QW-1];
	assign quo_u     = quo_u_s[QW-1];
	assign quo_v     = quo_v_s[QW-1];
	assign tag_out   = tag_s[QW-1];

endmodule

/* design/direction_to_cube_face_texel.sv */
// Top level: cube map face selection and texel addressing for a direction vector.
//
// A direction beat is offered on dir with start; it is taken at any clock edge
// where start is high and busy is low. busy stays low, so one direction can be
// taken in every cycle and the sustained rate is one beat per cycle.
// Each taken beat yields exactly one result beat on result, marked by a
// one-cycle done strobe. The divider resolves one quotient bit per stage for
// both coordinates. Stage one picks the major axis and face, stage two forms
// the scaled numerators, the divider stages follow, and a last stage clamps
// the texels.
// Results leave in the order the directions came in. The receiver cannot
// stall, so the pipeline never holds. Reset clears every valid bit, so beats
// in flight at reset are dropped and no result follows until new beats enter.
// An all-zero direction gives face -x, texels zero and the zero_vector flag.
module direction_to_cube_face_texel
	import dtcf_pkg::*;
#(
	parameter int FACE_SIZE = FACE_SIZE_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  dir_t   dir,
	output logic   done,
	output texel_t result
);

	localparam int QW = $clog2(FACE_SIZE + 1);
	localparam int NW = D_W + QW;
	localparam int LAT = QW + 3;
	localparam logic [NW-1:0] SIZE_N = NW'(FACE_SIZE);
	localparam logic [QW-1:0] QMAX = QW'(FACE_SIZE - 1);

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage one: magnitudes, major axis and face coordinates.
	logic signed [D_W-1:0] xs, ys, zs;
	logic [MAG_W-1:0]      ax, ay, az;
	logic [MAG_W-1:0]      m_c;
	logic signed [D_W-1:0] u_c, v_c;
	face_t                 face_c;

	always_comb begin
		xs = {dir.dir_x[COMP_W-1], dir.dir_x};
		ys = {dir.dir_y[COMP_W-1], dir.dir_y};
		zs = {dir.dir_z[COMP_W-1], dir.dir_z};
		ax = dir.dir_x[COMP_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
		ay = dir.dir_y[COMP_W-1] ? MAG_W'(-ys) : MAG_W'(ys);
		az = dir.dir_z[COMP_W-1] ? MAG_W'(-zs) : MAG_W'(zs);
		if (ax >= ay && ax >= az) begin
			m_c = ax;
			v_c = -ys;
			if (!dir.dir_x[COMP_W-1] && dir.dir_x != '0) begin
				face_c = FACE_POS_X;
				u_c    = -zs;
			end else begin
				face_c = FACE_NEG_X;
				u_c    = zs;
			end
		end else if (ay >= az) begin
			m_c = ay;
			u_c = xs;
			if (!dir.dir_y[COMP_W-1] && dir.dir_y != '0) begin
				face_c = FACE_POS_Y;
				v_c    = zs;
			end else begin
				face_c = FACE_NEG_Y;
				v_c    = -zs;
			end
		end else begin
			m_c = az;
			v_c = -ys;
			if (!dir.dir_z[COMP_W-1] && dir.dir_z != '0) begin
				face_c = FACE_POS_Z;
				u_c    = xs;
			end else begin
				face_c = FACE_NEG_Z;
				u_c    = -xs;
			end
		end
	end

	logic                  valid_s1;
	logic [MAG_W-1:0]      m_s1;
	logic signed [D_W-1:0] u_s1, v_s1;
	face_t                 face_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		m_s1    <= m_c;
		u_s1    <= u_c;
		v_s1    <= v_c;
		face_s1 <= face_c;
	end

	// Stage two: offset the coordinates into [0, 2m] and scale by the face size.
	logic [D_W-1:0] a_u, a_v;

	assign a_u = D_W'(u_s1) + {1'b0, m_s1};
	assign a_v = D_W'(v_s1) + {1'b0, m_s1};

	logic            valid_s2;
	logic [NW-1:0]   num_u_s2, num_v_s2;
	logic [D_W-1:0]  den_s2;
	dtcf_tag_t       tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_u_s2           <= NW'(a_u) * SIZE_N;
		num_v_s2           <= NW'(a_v) * SIZE_N;
		den_s2             <= {m_s1, 1'b0};
		tag_s2.face        <= face_s1;
		tag_s2.zero_vector <= (m_s1 == '0);
	end

	logic          div_valid;
	logic [QW-1:0] quo_u, quo_v;
	dtcf_tag_t     div_tag;

	dtcf_div #(
		.FACE_SIZE(FACE_SIZE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s2),
		.num_u    (num_u_s2),
		.num_v    (num_v_s2),
		.den      (den_s2),
		.tag_in   (tag_s2),
		.valid_out(div_valid),
		.quo_u    (quo_u),
		.quo_v    (quo_v),
		.tag_out  (div_tag)
	);

	// Last stage: a coordinate equal to +m lands one past the edge and is clamped.
	// A zero vector divides by zero in the divider, so its texels are forced here.
	logic [QW-1:0] clamp_u, clamp_v;

	assign clamp_u = (quo_u > QMAX) ? QMAX : quo_u;
	assign clamp_v = (quo_v > QMAX) ? QMAX : quo_v;

	logic   done_q;
	texel_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.face        <= div_tag.face;
		result_q.zero_vector <= div_tag.zero_vector;
		result_q.tex_x       <= div_tag.zero_vector ? '0 : TEX_W'(clamp_u);
		result_q.tex_y       <= div_tag.zero_vector ? '0 : TEX_W'(clamp_v);
	end

	assign done   = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result strobe missing after fixed latency");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_vector |->
			result.face == FACE_NEG_X && result.tex_x == '0 && result.tex_y == '0)
		else $error("zero vector result not forced");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.face <= FACE_NEG_Z)
		else $error("face code out of range");

endmodule
